// ===== rtl/acvt_pkg.sv =====
`default_nettype none

package acvt_pkg;

    typedef struct packed {
        logic [2:0] chan;
        logic [7:0] sample_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } out_item_t;

    // decoded reading handed from front to back
    typedef struct packed {
        logic [2:0] chan;
        logic       zero;
        logic [2:0] dig_thou;
        logic [3:0] dig_hund;
        logic [3:0] dig_tens;
        logic [3:0] dig_ones;
    } rec_t;

    // ceil(5000 * 2^17 / 255), exact floor for every 8-bit code
    localparam logic [21:0] MV_RECIP = 22'd2570040;
    localparam int          MV_SHIFT = 17;
    localparam int          MV_W     = 13;

    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_VOLT    = 8'h56;

    // character positions within one text
    localparam logic [3:0] POS_C     = 4'd0;
    localparam logic [3:0] POS_H     = 4'd1;
    localparam logic [3:0] POS_CHAN  = 4'd2;
    localparam logic [3:0] POS_COLON = 4'd3;
    localparam logic [3:0] POS_THOU  = 4'd4;
    localparam logic [3:0] POS_DOT   = 4'd5;
    localparam logic [3:0] POS_HUND  = 4'd6;
    localparam logic [3:0] POS_TENS  = 4'd7;
    localparam logic [3:0] POS_ONES  = 4'd8;
    localparam logic [3:0] POS_VOLT  = 4'd9;

endpackage

`default_nettype wire

// ===== rtl/adc_code_to_voltage_text.sv =====
// adc code to voltage text
// input channel: push / full, item carries chan and sample_code; a transaction
// completes on a clock edge with push high and full low
// result channel: empty / pop, result carries text_char and last_char; the
// oldest character is shown while empty is low and leaves on pop with empty low
// a reading of zero gives the six characters "ChN:0V", any other reading the
// ten characters "ChN:d.dddV"; last_char marks the final character
// millivolts come from one constant multiply, then the thousands and hundreds
// each take a pipeline stage, with tens and ones decoded from the last one;
// decoded readings wait in a small queue for the sequencer
// throughput: one character per cycle while pop is held and a reading waits,
// set by the single result register; new readings are taken every cycle
// until the queue and digit pipeline fill
// reset clears all valid state; the result channel reads empty afterwards
// while pop is low the shown character holds and the front keeps accepting
// until QUEUE_DEPTH readings plus three in the pipeline are waiting
`default_nettype none

module adc_code_to_voltage_text #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire acvt_pkg::in_item_t  item,
    output logic                     empty,
    input  wire logic                pop,
    output acvt_pkg::out_item_t      result
);
    import acvt_pkg::*;

    rec_t front_rec, head;
    logic front_valid, q_full, q_empty, q_pop;

    acvt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .rec_valid (front_valid),
        .rec_ready (!q_full),
        .rec       (front_rec)
    );

    acvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (front_valid),
        .wr_data (front_rec),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_data (head),
        .q_empty (q_empty)
    );

    acvt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== rtl/acvt_front.sv =====
`default_nettype none

module acvt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire acvt_pkg::in_item_t item,
    output logic                   rec_valid,
    input  wire logic              rec_ready,
    output acvt_pkg::rec_t         rec
);
    import acvt_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic [29:0]       prod;
    logic [MV_W-1:0]   mv1_reg;
    logic [2:0]        chan1_reg, chan2_reg, chan3_reg;
    logic              zero2_reg, zero3_reg;
    logic [2:0]        thou_next, thou2_reg, thou3_reg;
    logic [9:0]        rem1_next, rem1_reg;
    logic [3:0]        hund_next, hund3_reg;
    logic [6:0]        rem2_next, rem2_reg;
    logic [3:0]        tens, ones;

    assign rdy3 = !v3_reg || rec_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign full = !rdy1;

    assign prod = 30'(item.sample_code) * 30'(MV_RECIP);

    always_comb
    begin
        thou_next = 3'd0;
        for (int k = 1; k <= 5; k++)
        begin
            if (mv1_reg >= MV_W'(k * 1000))
            begin
                thou_next = 3'(k);
            end
        end
        rem1_next = 10'(mv1_reg - MV_W'(thou_next) * MV_W'(1000));
    end

    always_comb
    begin
        hund_next = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem1_reg >= 10'(k * 100))
            begin
                hund_next = 4'(k);
            end
        end
        rem2_next = 7'(rem1_reg - 10'(hund_next) * 10'd100);
    end

    always_comb
    begin
        tens = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem2_reg >= 7'(k * 10))
            begin
                tens = 4'(k);
            end
        end
        ones = 4'(rem2_reg - 7'(tens) * 7'd10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= push;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && push)
        begin
            chan1_reg <= item.chan;
            mv1_reg   <= prod[MV_SHIFT +: MV_W];
        end
        if (rdy2 && v1_reg)
        begin
            chan2_reg <= chan1_reg;
            zero2_reg <= (mv1_reg == '0);
            thou2_reg <= thou_next;
            rem1_reg  <= rem1_next;
        end
        if (rdy3 && v2_reg)
        begin
            chan3_reg <= chan2_reg;
            zero3_reg <= zero2_reg;
            thou3_reg <= thou2_reg;
            hund3_reg <= hund_next;
            rem2_reg  <= rem2_next;
        end
    end

    assign rec_valid    = v3_reg;
    assign rec.chan     = chan3_reg;
    assign rec.zero     = zero3_reg;
    assign rec.dig_thou = thou3_reg;
    assign rec.dig_hund = hund3_reg;
    assign rec.dig_tens = tens;
    assign rec.dig_ones = ones;

endmodule

`default_nettype wire

// ===== rtl/acvt_queue.sv =====
`default_nettype none

module acvt_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire acvt_pkg::rec_t wr_data,
    output logic                q_full,
    input  wire logic           rd,
    output acvt_pkg::rec_t      rd_data,
    output logic                q_empty
);
    import acvt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/acvt_back.sv =====
`default_nettype none

module acvt_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire acvt_pkg::rec_t head,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                empty,
    input  wire logic           pop,
    output acvt_pkg::out_item_t result
);
    import acvt_pkg::*;

    logic [3:0] pos_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;
    logic       advance;
    logic       last;
    logic [7:0] ch;

    assign advance = !q_empty && (!out_valid_reg || pop);
    assign last    = (head.zero && pos_reg == POS_DOT) || (pos_reg == POS_VOLT);
    assign q_pop   = advance && last;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        case (pos_reg)
            POS_C:     ch = CH_UPPER_C;
            POS_H:     ch = CH_LOWER_H;
            POS_CHAN:  ch = CH_DIGIT0 + 8'(head.chan);
            POS_COLON: ch = CH_COLON;
            POS_THOU:  ch = head.zero ? CH_DIGIT0 : CH_DIGIT0 + 8'(head.dig_thou);
            POS_DOT:   ch = head.zero ? CH_VOLT : CH_DOT;
            POS_HUND:  ch = CH_DIGIT0 + 8'(head.dig_hund);
            POS_TENS:  ch = CH_DIGIT0 + 8'(head.dig_tens);
            POS_ONES:  ch = CH_DIGIT0 + 8'(head.dig_ones);
            POS_VOLT:  ch = CH_VOLT;
            default:   ch = CH_VOLT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_C;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= last ? POS_C : pos_reg + 4'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.text_char <= ch;
            out_reg.last_char <= last;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_VOLT)
        else $error("character position out of range");

    a_zero_short: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && head.zero) |-> pos_reg <= POS_DOT)
        else $error("zero reading ran past its short text");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> pos_reg == POS_C)
        else $error("position not rewound after last character");
`endif

endmodule

`default_nettype wire
